[src/awlm_pkg.sv]
// ----------------------------------------------------------------------------
// awlm_pkg
// Shared types and constants for the windowed audio level meter.
// ----------------------------------------------------------------------------
package awlm_pkg;

  localparam int unsigned WINDOW_COUNT_BITS_DEF = 16;
  localparam int unsigned PHASE_COUNT_BITS_DEF  = 24;
  localparam int unsigned SAMPLE_SHIFT_DEF      = 8;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned SUM_W    = 62;
  localparam int unsigned SMOOTH_W = 32;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned CFG_W    = 24;

  // input beat kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_PHASE  = 2'd3;

  // register indexes
  localparam logic CFG_CLIP  = 1'b0;
  localparam logic CFG_ALPHA = 1'b1;

  localparam logic [23:0] CLIP_RESET  = 24'd8380000;
  localparam logic [8:0]  ALPHA_RESET = 9'd77;

  // controller to datapath commands
  typedef struct packed {
    logic take_in;    // latch input beat
    logic do_sample;  // accumulate a sample
    logic do_read;    // count a read-done
    logic div_start;  // load divider
    logic div_step;   // one quotient bit
    logic sqrt_start; // load root unit
    logic sqrt_step;  // one root bit pair
    logic finish;     // smooth, merge, build record, clear
  } awlm_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       div_last;
    logic       sqrt_last;
  } awlm_stat_t;

endpackage

[src/awlm_ctrl.sv]
// ----------------------------------------------------------------------------
// awlm_ctrl
// Sequencer: accepts beats, runs divide and square root for reports, and
// hands the record to the output register.
// ----------------------------------------------------------------------------
module awlm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  awlm_pkg::awlm_stat_t stat,
  output awlm_pkg::awlm_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DEC   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SQRT  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;

  // the record register must be free before a new record is built
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take_in = 1'b1;
          state_next  = ST_DEC;
        end
      end
      ST_DEC: begin
        unique case (stat.kind)
          awlm_pkg::KIND_SAMPLE: begin
            cmd.do_sample = 1'b1;
            state_next    = ST_IDLE;
          end
          awlm_pkg::KIND_READ: begin
            cmd.do_read = 1'b1;
            state_next  = ST_IDLE;
          end
          default: begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (stat.sqrt_last) begin
          state_next = ST_FIN;
        end
        cmd.sqrt_step = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_DIV && stat.div_last) begin
      cmd.sqrt_start = 1'b1;
      cmd.div_step   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_fin_from_sqrt: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> $past(state) == ST_SQRT)
    else $error("finish without root");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.take_in |-> $past(state) != ST_DIV || $past(rst))
    else $error("beat taken while busy");

endmodule

[src/awlm_datapath.sv]
// ----------------------------------------------------------------------------
// awlm_datapath
// Window and phase statistics, restoring divider, bitwise square root,
// smoothing and the output record register.
// ----------------------------------------------------------------------------
module awlm_datapath #(
  parameter int unsigned WINDOW_COUNT_BITS = awlm_pkg::WINDOW_COUNT_BITS_DEF,
  parameter int unsigned PHASE_COUNT_BITS  = awlm_pkg::PHASE_COUNT_BITS_DEF,
  parameter int unsigned SAMPLE_SHIFT      = awlm_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  awlm_pkg::awlm_cmd_t  cmd,
  output awlm_pkg::awlm_stat_t stat,
  input  logic [1:0]          kind,
  input  logic signed [31:0]  raw_word,
  input  logic                read_failed,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                record_kind,
  output logic [23:0]         sample_count,
  output logic signed [23:0]  raw_min,
  output logic signed [23:0]  raw_max,
  output logic [23:0]         peak,
  output logic [23:0]         rms_low,
  output logic [23:0]         rms_high,
  output logic [23:0]         zero_count,
  output logic [23:0]         clipped_count,
  output logic [23:0]         error_count,
  output logic [23:0]         read_count,
  output logic [23:0]         full_zero_reads
);

  localparam int unsigned WB = WINDOW_COUNT_BITS;
  localparam int unsigned PB = PHASE_COUNT_BITS;
  localparam int unsigned SW = awlm_pkg::SUM_W;
  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = -24'sh800000;
  localparam int unsigned SUM_STEPS = SW;     // divide steps
  localparam int unsigned RT_STEPS  = 31;     // root steps, 2 bits each
  localparam int unsigned CW = 6;

  // config
  logic [23:0] clip_th;
  logic [8:0]  alpha;
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_th <= awlm_pkg::CLIP_RESET;
      alpha   <= awlm_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      if (cfg_index == awlm_pkg::CFG_CLIP) clip_th <= cfg_data;
      else alpha <= cfg_data[8:0];
    end
  end

  // latched beat
  logic [1:0]  k_q;
  logic signed [31:0] w_q;
  logic        f_q;
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      k_q <= kind;
      w_q <= raw_word;
      f_q <= read_failed;
    end
  end

  // sample conditioning: floor shift, clamp
  logic signed [31:0] shifted;
  logic signed [23:0] s;
  logic [23:0] mag;
  logic [47:0] sq;
  assign shifted = w_q >>> SAMPLE_SHIFT;
  always_comb begin
    if (shifted > 32'(S_MAX)) s = S_MAX;
    else if (shifted < 32'(S_MIN)) s = S_MIN;
    else s = shifted[23:0];
    mag = s[23] ? 24'(-s) : s;
    sq = mag * mag;
  end

  // window state
  logic signed [23:0] w_min, w_max, p_min, p_max;
  logic [23:0] w_peak, p_peak, p_rmin, p_rmax;
  logic [SW-1:0] w_sum;
  logic [WB-1:0] w_n, w_z, w_c, w_e, w_r, w_fz;
  logic          all_zero;
  logic [PB-1:0] p_n, p_z, p_c, p_e, p_r, p_fz;
  logic [31:0]   smoothed;

  function automatic logic [WB-1:0] winc(input logic [WB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction
  function automatic logic [PB-1:0] padd(input logic [PB-1:0] a,
                                         input logic [WB-1:0] b);
    logic [PB:0] t;
    t = {1'b0, a} + (PB+1)'(b);
    return t[PB] ? {PB{1'b1}} : t[PB-1:0];
  endfunction
  function automatic logic [23:0] o24(input logic [PB-1:0] v);
    return (PB > 24 && (v >> 24) != 0) ? 24'hFFFFFF : 24'(v);
  endfunction
  function automatic logic [23:0] ow24(input logic [WB-1:0] v);
    return 24'(v);
  endfunction

  // restoring divider: sum / samples
  logic [SW-1:0] q_rem_num;
  logic [WB:0]   rem;
  logic [CW-1:0] cnt;
  logic [SW-1:0] quo;
  logic [WB+1:0] rem_sh, rem_sub;
  always_comb begin
    rem_sh  = {rem, q_rem_num[SW-1]};
    rem_sub = rem_sh - (WB+2)'(w_n);
  end

  // square root of quotient, two bits a step
  logic [SW-1:0] rx;
  logic [31:0]   rroot;
  logic [33:0]   racc;
  logic [33:0]   rtrial, racc_sh;
  always_comb begin
    racc_sh = {racc[31:0], rx[SW-1:SW-2]};
    rtrial  = racc_sh - {rroot, 2'b01};
  end
  // an empty window has RMS 0 (the divider result is meaningless then)
  logic has;
  assign has = (w_n != 0);
  logic [23:0] rms;
  assign rms = has ? 24'(rroot) : 24'd0;

  assign stat.kind      = k_q;
  assign stat.div_last  = (cnt == CW'(SUM_STEPS - 1));
  assign stat.sqrt_last = (cnt == CW'(RT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_rem_num <= w_sum;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      q_rem_num <= {q_rem_num[SW-2:0], 1'b0};
      if (!rem_sub[WB+1]) begin
        rem <= rem_sub[WB:0];
        quo <= {quo[SW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[WB:0];
        quo <= {quo[SW-2:0], 1'b0};
      end
    end else if (cmd.sqrt_start) begin
      cnt   <= '0;
      racc  <= '0;
      rroot <= '0;
      rx    <= {quo[SW-2:0], !rem_sub[WB+1]};
    end else if (cmd.sqrt_step) begin
      cnt <= cnt + 1'b1;
      rx  <= {rx[SW-3:0], 2'b00};
      if (!rtrial[33]) begin
        racc  <= rtrial;
        rroot <= {rroot[30:0], 1'b1};
      end else begin
        racc  <= racc_sh;
        rroot <= {rroot[30:0], 1'b0};
      end
    end
  end

  // smoothing step
  logic [8:0]  a_eff;
  logic signed [33:0] diff;
  logic signed [43:0] prod;
  logic [43:0] pabs;
  logic signed [35:0] qstep;
  assign a_eff = (alpha > 9'd256) ? 9'd256 : alpha;
  always_comb begin
    diff  = (has ? $signed({2'b00, rms, 8'b0}) : 34'sd0) - $signed({2'b00, smoothed});
    prod  = diff * $signed({1'b0, a_eff});
    pabs  = prod[43] ? 44'(-prod) : 44'(prod);
    qstep = prod[43] ? -$signed({1'b0, 35'(pabs >> 8)}) : $signed({1'b0, 35'(pabs >> 8)});
  end

  // merged phase values
  logic merge;
  logic signed [23:0] m_min, m_max;
  logic [23:0] m_peak, m_rmin, m_rmax;
  logic [PB-1:0] m_n, m_z, m_c, m_e, m_r, m_fz;
  always_comb begin
    merge = (w_n != 0) || (w_e != 0);
    m_min = p_min; m_max = p_max; m_peak = p_peak; m_rmin = p_rmin; m_rmax = p_rmax;
    m_n = p_n; m_z = p_z; m_c = p_c; m_e = p_e; m_r = p_r; m_fz = p_fz;
    if (merge) begin
      if (w_min < p_min) m_min = w_min;
      if (w_max > p_max) m_max = w_max;
      if (w_peak > p_peak) m_peak = w_peak;
      if (has) begin
        if (rms < p_rmin) m_rmin = rms;
        if (rms > p_rmax) m_rmax = rms;
      end
      m_n = padd(p_n, w_n); m_z = padd(p_z, w_z); m_c = padd(p_c, w_c);
      m_e = padd(p_e, w_e); m_r = padd(p_r, w_r); m_fz = padd(p_fz, w_fz);
    end
  end

  logic [31:0] sm_new;
  assign sm_new = smoothed + 32'(qstep);
  logic clr_win, clr_ph;
  assign clr_win = cmd.finish;
  assign clr_ph  = cmd.finish && (k_q == awlm_pkg::KIND_PHASE);

  // window registers
  always_ff @(posedge clk) begin
    if (rst || clr_win) begin
      w_min <= S_MAX; w_max <= S_MIN; w_peak <= '0; w_sum <= '0;
      w_n <= '0; w_z <= '0; w_c <= '0; w_e <= '0; w_r <= '0; w_fz <= '0;
      all_zero <= 1'b1;
    end else if (cmd.do_sample) begin
      if (s < w_min) w_min <= s;
      if (s > w_max) w_max <= s;
      if (mag > w_peak) w_peak <= mag;
      w_sum <= (w_sum > {SW{1'b1}} - SW'(sq)) ? {SW{1'b1}} : w_sum + SW'(sq);
      if (s == 0) w_z <= winc(w_z);
      else all_zero <= 1'b0;
      if (mag >= clip_th) w_c <= winc(w_c);
      w_n <= winc(w_n);
    end else if (cmd.do_read) begin
      w_r <= winc(w_r);
      if (f_q) w_e <= winc(w_e);
      else if (all_zero) w_fz <= winc(w_fz);
      all_zero <= 1'b1;
    end
  end

  // phase registers and smoothing
  always_ff @(posedge clk) begin
    if (rst) smoothed <= '0;
    else if (cmd.finish && k_q == awlm_pkg::KIND_REPORT) smoothed <= sm_new;
  end
  always_ff @(posedge clk) begin
    if (rst || clr_ph) begin
      p_min <= S_MAX; p_max <= S_MIN; p_peak <= '0; p_rmin <= 24'hFFFFFF; p_rmax <= '0;
      p_n <= '0; p_z <= '0; p_c <= '0; p_e <= '0; p_r <= '0; p_fz <= '0;
    end else if (cmd.finish) begin
      p_min <= m_min; p_max <= m_max; p_peak <= m_peak; p_rmin <= m_rmin; p_rmax <= m_rmax;
      p_n <= m_n; p_z <= m_z; p_c <= m_c; p_e <= m_e; p_r <= m_r; p_fz <= m_fz;
    end
  end

  // output record register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (k_q == awlm_pkg::KIND_REPORT) begin
        record_kind <= 1'b0;
        sample_count <= ow24(w_n);
        raw_min <= has ? w_min : '0;
        raw_max <= has ? w_max : '0;
        peak <= w_peak; rms_low <= rms; rms_high <= sm_new[31:8];
        zero_count <= ow24(w_z); clipped_count <= ow24(w_c);
        error_count <= ow24(w_e); read_count <= ow24(w_r);
        full_zero_reads <= ow24(w_fz);
      end else begin
        record_kind <= 1'b1;
        sample_count <= o24(m_n);
        raw_min <= m_min; raw_max <= m_max; peak <= m_peak;
        rms_low <= (m_rmin == 24'hFFFFFF) ? '0 : m_rmin;
        rms_high <= m_rmax;
        zero_count <= o24(m_z); clipped_count <= o24(m_c);
        error_count <= o24(m_e); read_count <= o24(m_r);
        full_zero_reads <= o24(m_fz);
      end
    end
  end

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && has |-> rroot[31:24] == 8'd0)
    else $error("root out of range");
  a_clear_after_finish: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.finish) && !$past(rst) |-> w_n == '0 && all_zero)
    else $error("window not cleared");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid || out_ready || $past(out_ready))
    else $error("record overwritten");

endmodule

[src/audio_window_level_meter.sv]
// ----------------------------------------------------------------------------
// audio_window_level_meter
// Windowed level meter: min, max, peak, RMS, smoothed RMS and event counts.
// ----------------------------------------------------------------------------
// Input beats (valid/ready) carry kind, raw_word and read_failed. A sample or
// read-done beat gives no record. A report or phase-end beat gives one
// record on the output channel (valid/ready): the beat is decoded, the sum
// of squares is divided by the sample count in a restoring divider (the last
// quotient bit goes straight into the root unit), the bitwise square root is
// taken, and a final step merges into the phase totals, smooths the RMS for
// a report and loads the record register. The divider and root unit limit
// how often reports can be made. One beat is in flight at a time. in_ready
// is low while a beat is worked and while a record waits in the output
// register; a stalled receiver thus holds off new beats but no record is
// lost. Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once
// and must be made while idle; the block itself does not enforce this.
// Reset clears all statistics, the smoothed RMS and restores the clip
// threshold (8380000) and smoothing factor (77/256).
// ----------------------------------------------------------------------------
module audio_window_level_meter #(
  parameter int unsigned WINDOW_COUNT_BITS = awlm_pkg::WINDOW_COUNT_BITS_DEF,
  parameter int unsigned PHASE_COUNT_BITS  = awlm_pkg::PHASE_COUNT_BITS_DEF,
  parameter int unsigned SAMPLE_SHIFT      = awlm_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] raw_word,
  input  logic               read_failed,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               record_kind,
  output logic [23:0]        sample_count,
  output logic signed [23:0] raw_min,
  output logic signed [23:0] raw_max,
  output logic [23:0]        peak,
  output logic [23:0]        rms_low,
  output logic [23:0]        rms_high,
  output logic [23:0]        zero_count,
  output logic [23:0]        clipped_count,
  output logic [23:0]        error_count,
  output logic [23:0]        read_count,
  output logic [23:0]        full_zero_reads
);

  awlm_pkg::awlm_cmd_t  cmd;
  awlm_pkg::awlm_stat_t stat;

  awlm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  awlm_datapath #(
    .WINDOW_COUNT_BITS(WINDOW_COUNT_BITS),
    .PHASE_COUNT_BITS (PHASE_COUNT_BITS),
    .SAMPLE_SHIFT     (SAMPLE_SHIFT)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .kind, .raw_word, .read_failed,
    .cfg_we, .cfg_index, .cfg_data, .out_valid, .out_ready,
    .record_kind, .sample_count, .raw_min, .raw_max, .peak, .rms_low,
    .rms_high, .zero_count, .clipped_count, .error_count, .read_count,
    .full_zero_reads
  );

endmodule
